/* design/lsl_pkg.sv */
// Shared constants, coefficient tables and types for the lux converter.
// No dependencies; compiled first.
package lsl_pkg;

  localparam int COUNT_W  = 16;
  localparam int SCALE_W  = 19;
  localparam int CH_SCALE = 10;
  localparam int CH_W     = 25;
  localparam int QUOT_W   = 11;
  localparam int REM_W    = CH_W + QUOT_W;
  localparam int PROD_W   = 35;
  localparam int COEF_W   = 10;
  localparam int LUX_SCALE = 14;
  localparam int VAL_W    = PROD_W - LUX_SCALE + 1;
  localparam int LUX_W    = 16;
  localparam int SEG_W    = 3;
  localparam int N_KNEES  = 7;
  localparam int N_SEGS   = 8;

  localparam int DIV_INIT  = 2;
  localparam int DIV_FIRST = 3;
  localparam int SEG_STAGE = DIV_FIRST + QUOT_W;
  localparam int MUL_STAGE = SEG_STAGE + 1;
  localparam int SUB_STAGE = SEG_STAGE + 2;
  localparam int N_STAGES  = SEG_STAGE + 3;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEGRATION_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_GAIN        = 1'b1;

  localparam logic [1:0] MODE_T13  = 2'd0;
  localparam logic [1:0] MODE_T101 = 2'd1;
  localparam logic [1:0] MODE_T402 = 2'd2;

  localparam logic [SCALE_W-1:0] SCALE_T13  = 19'h07517;
  localparam logic [SCALE_W-1:0] SCALE_T101 = 19'h00FE7;
  localparam logic [SCALE_W-1:0] SCALE_UNIT = 19'h00400;

  localparam logic [PROD_W-1:0] LUX_ROUND = PROD_W'(1) << (LUX_SCALE - 1);
  localparam logic [VAL_W-1:0]  LUX_MAX   = VAL_W'(16'hFFFF);

  typedef logic [COEF_W-1:0] coef_t;

  localparam coef_t KNEE [0:N_KNEES-1] = '{
    10'h040, 10'h080, 10'h0c0, 10'h100, 10'h138, 10'h19a, 10'h29a
  };
  localparam coef_t OFFSET [0:N_SEGS-1] = '{
    10'h1f2, 10'h214, 10'h23f, 10'h270, 10'h16f, 10'h0d2, 10'h018, 10'h000
  };
  localparam coef_t SLOPE [0:N_SEGS-1] = '{
    10'h1be, 10'h2d1, 10'h37b, 10'h3fe, 10'h1fc, 10'h0fb, 10'h012, 10'h000
  };

  typedef struct packed {
    logic [CH_W-1:0]   ch0;
    logic [CH_W-1:0]   ch1;
    logic [REM_W-1:0]  rem;
    logic [QUOT_W-1:0] quot;
    logic              zero;
    logic              big;
    logic [SEG_W-1:0]  seg;
    logic [PROD_W-1:0] pos;
    logic [PROD_W-1:0] neg;
    logic [PROD_W-1:0] diff;
    logic [LUX_W-1:0]  lux;
    logic              sat;
  } pipe_t;

  function automatic logic [SCALE_W-1:0] scale_of(input logic [1:0] mode,
                                                  input logic high_gain);
    logic [SCALE_W-1:0] base;
    unique case (mode)
      MODE_T13:  base = SCALE_T13;
      MODE_T101: base = SCALE_T101;
      MODE_T402: base = SCALE_UNIT;
      default:   base = SCALE_UNIT;
    endcase
    return high_gain ? base : (base << 4);
  endfunction

endpackage

/* design/lsl_if.sv */
// Valid/ready channels for count pairs and lux results.
// Uses lsl_pkg for field widths.
interface lsl_sample_if;
  logic                          valid;
  logic                          ready;
  logic [lsl_pkg::COUNT_W-1:0]   broadband_count;
  logic [lsl_pkg::COUNT_W-1:0]   infrared_count;

  modport source (output valid, broadband_count, infrared_count, input ready);
  modport sink   (input valid, broadband_count, infrared_count, output ready);
endinterface

interface lsl_result_if;
  logic                        valid;
  logic                        ready;
  logic [lsl_pkg::LUX_W-1:0]   lux;
  logic                        saturated;

  modport source (output valid, lux, saturated, input ready);
  modport sink   (input valid, lux, saturated, output ready);
endinterface

/* design/light_sensor_lux_calc_unit.sv */
// Lux converter top level: 17-stage pipeline from count pair to lux.
// Depends on lsl_pkg and the channel interfaces in lsl_if.sv.
//
// Converts one broadband/infrared count pair per clock into rounded whole lux
// (while the result is not stalled), using the eight-segment T-package formula;
// saturated flags lux clipped to 65535. The ratio is formed by an 11-step
// restoring divider, one quotient bit per stage, which sets most of the
// pipeline depth. Every stage carries its own valid bit and only moves when
// the stage after it is free, so bubbles fill in behind a stalled result and
// new samples keep being taken while any stage is empty.
// Write integration_mode (index 0) and high_gain (index 1) only while idle.
module light_sensor_lux_calc_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [lsl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lsl_pkg::CFG_DATA_W-1:0]    cfg_data,
  lsl_sample_if.sink                        sample,
  lsl_result_if.source                      result
);

  localparam int N = lsl_pkg::N_STAGES;

  logic [1:0] integration_mode;
  logic       high_gain;

  lsl_pkg::pipe_t stg [1:N];
  lsl_pkg::pipe_t nxt [1:N];
  logic           v   [1:N];
  logic           en  [1:N+1];

  logic [lsl_pkg::SCALE_W-1:0] scale;
  logic [lsl_pkg::PROD_W-1:0]  p0;
  logic [lsl_pkg::PROD_W-1:0]  p1;

  always_ff @(posedge clk) begin
    if (rst) begin
      integration_mode <= lsl_pkg::MODE_T402;
      high_gain        <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        lsl_pkg::CFG_INTEGRATION_MODE: integration_mode <= cfg_data[1:0];
        lsl_pkg::CFG_HIGH_GAIN:        high_gain        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Backpressure: a stage may load when empty or when its item moves on.
  always_comb begin
    en[N+1] = result.ready;
    for (int s = N; s >= 1; s--) begin
      en[s] = !v[s] || en[s+1];
    end
  end

  assign sample.ready = en[1];

  assign scale = lsl_pkg::scale_of(integration_mode, high_gain);
  assign p0 = lsl_pkg::PROD_W'(sample.broadband_count) * lsl_pkg::PROD_W'(scale);
  assign p1 = lsl_pkg::PROD_W'(sample.infrared_count) * lsl_pkg::PROD_W'(scale);

  always_comb begin
    logic [lsl_pkg::REM_W-1:0]  dsh;
    logic [lsl_pkg::QUOT_W-1:0] q;
    logic [lsl_pkg::QUOT_W-1:0] r;
    logic [lsl_pkg::SEG_W-1:0]  seg;
    logic [lsl_pkg::PROD_W-1:0] rounded;
    logic [lsl_pkg::VAL_W-1:0]  val;

    // Scale counts to the reference integration time and gain.
    nxt[1]     = '0;
    nxt[1].ch0 = lsl_pkg::CH_W'(p0 >> lsl_pkg::CH_SCALE);
    nxt[1].ch1 = lsl_pkg::CH_W'(p1 >> lsl_pkg::CH_SCALE);

    // Set up the divider; quotients of 2048 and above only need a flag.
    nxt[lsl_pkg::DIV_INIT]      = stg[lsl_pkg::DIV_INIT-1];
    nxt[lsl_pkg::DIV_INIT].rem  = {1'b0, stg[lsl_pkg::DIV_INIT-1].ch1,
                                   lsl_pkg::CH_SCALE'(0)};
    nxt[lsl_pkg::DIV_INIT].quot = '0;
    nxt[lsl_pkg::DIV_INIT].zero = (stg[lsl_pkg::DIV_INIT-1].ch0 == '0);
    nxt[lsl_pkg::DIV_INIT].big  = ({1'b0, stg[lsl_pkg::DIV_INIT-1].ch1} >=
                                   {stg[lsl_pkg::DIV_INIT-1].ch0, 1'b0});

    for (int k = 0; k < lsl_pkg::QUOT_W; k++) begin
      nxt[lsl_pkg::DIV_FIRST+k] = stg[lsl_pkg::DIV_FIRST+k-1];
      dsh = lsl_pkg::REM_W'(stg[lsl_pkg::DIV_FIRST+k-1].ch0) << (lsl_pkg::QUOT_W-1-k);
      if (stg[lsl_pkg::DIV_FIRST+k-1].rem >= dsh) begin
        nxt[lsl_pkg::DIV_FIRST+k].rem = stg[lsl_pkg::DIV_FIRST+k-1].rem - dsh;
        nxt[lsl_pkg::DIV_FIRST+k].quot[lsl_pkg::QUOT_W-1-k] = 1'b1;
      end
    end

    // Round the ratio and pick the segment.
    nxt[lsl_pkg::SEG_STAGE] = stg[lsl_pkg::SEG_STAGE-1];
    priority if (stg[lsl_pkg::SEG_STAGE-1].zero) begin
      q = '0;
    end else if (stg[lsl_pkg::SEG_STAGE-1].big) begin
      q = '1;
    end else begin
      q = stg[lsl_pkg::SEG_STAGE-1].quot;
    end
    r = lsl_pkg::QUOT_W'(({1'b0, q} + (lsl_pkg::QUOT_W+1)'(1)) >> 1);
    seg = lsl_pkg::SEG_W'(lsl_pkg::N_SEGS - 1);
    for (int k = lsl_pkg::N_KNEES - 1; k >= 0; k--) begin
      if (r <= lsl_pkg::QUOT_W'(lsl_pkg::KNEE[k])) begin
        seg = lsl_pkg::SEG_W'(k);
      end
    end
    nxt[lsl_pkg::SEG_STAGE].seg = seg;

    nxt[lsl_pkg::MUL_STAGE]     = stg[lsl_pkg::MUL_STAGE-1];
    nxt[lsl_pkg::MUL_STAGE].pos =
      lsl_pkg::PROD_W'(stg[lsl_pkg::MUL_STAGE-1].ch0) *
      lsl_pkg::PROD_W'(lsl_pkg::OFFSET[stg[lsl_pkg::MUL_STAGE-1].seg]);
    nxt[lsl_pkg::MUL_STAGE].neg =
      lsl_pkg::PROD_W'(stg[lsl_pkg::MUL_STAGE-1].ch1) *
      lsl_pkg::PROD_W'(lsl_pkg::SLOPE[stg[lsl_pkg::MUL_STAGE-1].seg]);

    // Clamp a negative difference to zero.
    nxt[lsl_pkg::SUB_STAGE] = stg[lsl_pkg::SUB_STAGE-1];
    nxt[lsl_pkg::SUB_STAGE].diff =
      (stg[lsl_pkg::SUB_STAGE-1].pos > stg[lsl_pkg::SUB_STAGE-1].neg) ?
      (stg[lsl_pkg::SUB_STAGE-1].pos - stg[lsl_pkg::SUB_STAGE-1].neg) : '0;

    nxt[N]     = stg[N-1];
    rounded    = stg[N-1].diff + lsl_pkg::LUX_ROUND;
    val        = lsl_pkg::VAL_W'(rounded >> lsl_pkg::LUX_SCALE);
    nxt[N].sat = (val > lsl_pkg::LUX_MAX);
    nxt[N].lux = nxt[N].sat ? '1 : val[lsl_pkg::LUX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 1; s <= N; s++) begin
        v[s] <= 1'b0;
      end
    end else begin
      if (en[1]) begin
        v[1] <= sample.valid;
      end
      for (int s = 2; s <= N; s++) begin
        if (en[s]) begin
          v[s] <= v[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 1; s <= N; s++) begin
      if (en[s]) begin
        stg[s] <= nxt[s];
      end
    end
  end

  assign result.valid     = v[N];
  assign result.lux       = stg[N].lux;
  assign result.saturated = stg[N].sat;

`ifndef SYNTHESIS
  a_ready_low_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !sample.ready |-> (v[1] && v[lsl_pkg::SEG_STAGE] && v[N]))
    else $error("sample stalled while the pipeline has room");

  a_div_remainder_below_divisor: assert property (@(posedge clk) disable iff (rst)
    v[lsl_pkg::SEG_STAGE-1] && !stg[lsl_pkg::SEG_STAGE-1].zero &&
    !stg[lsl_pkg::SEG_STAGE-1].big |->
    stg[lsl_pkg::SEG_STAGE-1].rem <
      lsl_pkg::REM_W'(stg[lsl_pkg::SEG_STAGE-1].ch0))
    else $error("divider remainder not below divisor");

  a_diff_bounded: assert property (@(posedge clk) disable iff (rst)
    v[lsl_pkg::SUB_STAGE] |->
    stg[lsl_pkg::SUB_STAGE].diff <= stg[lsl_pkg::SUB_STAGE].pos)
    else $error("clamped difference exceeds positive term");

  a_saturated_clips: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.saturated |-> result.lux == 16'hFFFF)
    else $error("saturated result not clipped");
`endif

endmodule

/* dv/tb_light_sensor_lux_calc_unit.sv */
`timescale 1ns / 100ps
// Self-checking bench for light_sensor_lux_calc_unit: count pairs in, lux out.
// Depends on lsl_pkg, lsl_sample_if/lsl_result_if and the unit itself.
module tb_light_sensor_lux_calc_unit;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_AT = 450;
  localparam int HOLD_LEN = 400;
  localparam int TAIL_CYCLES = 40;
  localparam int PHASE_ITEMS = 130;
  localparam int N_PHASES = 8;
  localparam int MAX_PRINTS = 50;

  localparam int RX_OPEN = 0;
  localparam int RX_COIN = 1;
  localparam int RX_THIRD = 2;
  localparam int RX_SPARSE = 3;

  localparam logic [9:0] LUX_KNEE [0:6] = '{
    10'h040, 10'h080, 10'h0c0, 10'h100, 10'h138, 10'h19a, 10'h29a
  };
  localparam logic [9:0] LUX_OFFSET [0:7] = '{
    10'h1f2, 10'h214, 10'h23f, 10'h270, 10'h16f, 10'h0d2, 10'h018, 10'h000
  };
  localparam logic [9:0] LUX_SLOPE [0:7] = '{
    10'h1be, 10'h2d1, 10'h37b, 10'h3fe, 10'h1fc, 10'h0fb, 10'h012, 10'h000
  };

  localparam logic [1:0] PHASE_MODE [0:N_PHASES-1] = '{
    lsl_pkg::MODE_T13, lsl_pkg::MODE_T13, lsl_pkg::MODE_T101, lsl_pkg::MODE_T101,
    lsl_pkg::MODE_T402, MODE_SPARE, MODE_SPARE, lsl_pkg::MODE_T402
  };
  localparam logic PHASE_GAIN [0:N_PHASES-1] = '{
    1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0
  };

  typedef struct packed {
    logic [lsl_pkg::COUNT_W-1:0] broadband;
    logic [lsl_pkg::COUNT_W-1:0] infrared;
  } count_pair_t;

  typedef struct packed {
    logic [lsl_pkg::LUX_W-1:0] lux;
    logic                      saturated;
  } lux_result_t;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [lsl_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [lsl_pkg::CFG_DATA_W-1:0] cfg_data;

  lsl_sample_if sample_ch ();
  lsl_result_if result_ch ();

  light_sensor_lux_calc_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample_ch),
    .result    (result_ch)
  );

  logic [1:0] mode_reg;
  logic gain_reg;

  count_pair_t pairs_to_send [$];
  lux_result_t lux_due [$];

  bit sample_fire;
  bit result_fire;
  int samples_in;
  int results_out;
  int pairs_pushed;
  int mismatches;
  int stall_cycles;

  int burst_left;
  int gap_left;
  count_pair_t next_pair;

  int rx_style;
  int style_left;
  int rx_tick;
  int hold_left;
  bit hold_done;

  lux_result_t want;

  initial begin
    clk = 1'b0;
  end

  always begin
    #1 clk = ~clk;
  end

  function automatic lux_result_t compute_lux(input logic [lsl_pkg::COUNT_W-1:0] bb,
                                              input logic [lsl_pkg::COUNT_W-1:0] ir);
    logic [63:0] scale;
    logic [63:0] ch0;
    logic [63:0] ch1;
    logic [63:0] ratio;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] val;
    int seg;
    int k;
    lux_result_t r;
    case (mode_reg)
      lsl_pkg::MODE_T13: scale = 64'h7517;
      lsl_pkg::MODE_T101: scale = 64'h0FE7;
      default: scale = 64'h0400;
    endcase
    if (!gain_reg) begin
      scale = scale << 4;
    end
    ch0 = ({48'd0, bb} * scale) >> 10;
    ch1 = ({48'd0, ir} * scale) >> 10;
    ratio = (ch0 != 64'd0) ? ((ch1 << 10) / ch0) : 64'd0;
    ratio = (ratio + 64'd1) >> 1;
    seg = 7;
    for (k = 6; k >= 0; k--) begin
      if (ratio <= {54'd0, LUX_KNEE[k]}) begin
        seg = k;
      end
    end
    pos = ch0 * {54'd0, LUX_OFFSET[seg]};
    neg = ch1 * {54'd0, LUX_SLOPE[seg]};
    val = (pos > neg) ? (pos - neg) : 64'd0;
    val = (val + 64'd8192) >> 14;
    if (val > 64'd65535) begin
      r.lux = 16'hFFFF;
      r.saturated = 1'b1;
    end else begin
      r.lux = val[15:0];
      r.saturated = 1'b0;
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string what);
    if (mismatches < MAX_PRINTS) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
    mismatches++;
  endtask

  // monitor: predict on sample transfer, check on result transfer
  always @(posedge clk) begin
    sample_fire = 1'b0;
    result_fire = 1'b0;
    if (!rst) begin
      if (sample_ch.valid && sample_ch.ready) begin
        lux_due.push_back(compute_lux(sample_ch.broadband_count, sample_ch.infrared_count));
        sample_fire = 1'b1;
        samples_in++;
      end
      if (result_ch.valid && result_ch.ready) begin
        result_fire = 1'b1;
        if (lux_due.size() == 0) begin
          flag_mismatch($sformatf("result %0d arrived with nothing outstanding", results_out));
        end else begin
          want = lux_due.pop_front();
          if (result_ch.lux !== want.lux) begin
            flag_mismatch($sformatf("result %0d lux %0d, predicted %0d",
                                    results_out, result_ch.lux, want.lux));
          end
          if (result_ch.saturated !== want.saturated) begin
            flag_mismatch($sformatf("result %0d saturated %b, predicted %b",
                                    results_out, result_ch.saturated, want.saturated));
          end
        end
        results_out++;
      end
    end
  end

  // sender: bursts of random length separated by random gaps
  always @(negedge clk) begin
    if (rst) begin
      sample_ch.valid <= 1'b0;
    end else if (!sample_ch.valid || sample_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        sample_ch.valid <= 1'b0;
      end else if (pairs_to_send.size() > 0) begin
        next_pair = pairs_to_send.pop_front();
        sample_ch.broadband_count <= next_pair.broadband;
        sample_ch.infrared_count <= next_pair.infrared;
        sample_ch.valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        sample_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: switch between stall styles, one long hold-off mid-run
  always @(negedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      rx_tick++;
      if (!hold_done && samples_in >= HOLD_AT && pairs_to_send.size() > 40) begin
        hold_left = HOLD_LEN;
        hold_done = 1'b1;
      end
      if (style_left == 0) begin
        rx_style = $urandom_range(RX_OPEN, RX_SPARSE);
        style_left = $urandom_range(20, 200);
      end else begin
        style_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        case (rx_style)
          RX_OPEN: result_ch.ready <= 1'b1;
          RX_COIN: result_ch.ready <= ($urandom_range(0, 1) == 1);
          RX_THIRD: result_ch.ready <= (rx_tick % 3 == 0);
          default: result_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (sample_fire || result_fire) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("light_sensor_lux_calc_unit regression: fail");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [lsl_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lsl_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == lsl_pkg::CFG_INTEGRATION_MODE) begin
      mode_reg = val;
    end else begin
      gain_reg = val[0];
    end
  endtask

  // hold until every queued pair has come back as a result
  task automatic wait_drained();
    while (results_out != pairs_pushed) begin
      @(negedge clk);
    end
  endtask

  task automatic push_pair(input logic [lsl_pkg::COUNT_W-1:0] bb,
                           input logic [lsl_pkg::COUNT_W-1:0] ir);
    count_pair_t p;
    p.broadband = bb;
    p.infrared = ir;
    pairs_to_send.push_back(p);
    pairs_pushed++;
  endtask

  function automatic logic [lsl_pkg::COUNT_W-1:0] extreme_count();
    case ($urandom_range(0, 4))
      0: return 16'h0000;
      1: return 16'h0001;
      2: return 16'hFFFF;
      3: return 16'hFFFE;
      default: return 16'($urandom());
    endcase
  endfunction

  // mostly infrared as a spread fraction of broadband, so every segment is hit
  task automatic queue_random(input int n);
    int i;
    int sel;
    int unsigned bb;
    int unsigned ir;
    int unsigned mask;
    for (i = 0; i < n; i++) begin
      sel = $urandom_range(0, 9);
      mask = (32'd1 << $urandom_range(1, 16)) - 32'd1;
      bb = $urandom() & mask;
      if (sel < 6) begin
        ir = (bb * $urandom_range(0, 1400)) >> 10;
        if (ir > 65535) begin
          ir = 65535;
        end
        push_pair(bb[15:0], ir[15:0]);
      end else if (sel < 8) begin
        ir = $urandom() & mask;
        push_pair(bb[15:0], ir[15:0]);
      end else begin
        push_pair(extreme_count(), extreme_count());
      end
    end
  endtask

  initial begin
    int k;
    int ph;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = lsl_pkg::CFG_INTEGRATION_MODE;
    cfg_data = '0;
    sample_ch.valid = 1'b0;
    sample_ch.broadband_count = '0;
    sample_ch.infrared_count = '0;
    result_ch.ready = 1'b0;
    mode_reg = lsl_pkg::MODE_T402;
    gain_reg = 1'b0;
    burst_left = 1;
    gap_left = 0;
    style_left = 0;
    rx_style = RX_OPEN;
    rx_tick = 0;
    hold_left = 0;
    hold_done = 1'b0;
    samples_in = 0;
    results_out = 0;
    pairs_pushed = 0;
    mismatches = 0;
    stall_cycles = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    push_pair(16'h0000, 16'h0000);
    push_pair(16'hFFFF, 16'hFFFF);
    push_pair(16'hFFFF, 16'h0000);
    push_pair(16'h0000, 16'hFFFF);
    push_pair(16'h0001, 16'h0000);
    push_pair(16'h0000, 16'h0001);
    push_pair(16'h0001, 16'h0001);
    push_pair(16'hFFFF, 16'h0001);
    push_pair(16'd100, 16'd200);
    // ratio exactly on each knee, then half a step past it
    for (k = 0; k < 7; k++) begin
      push_pair(16'd4096, {3'd0, LUX_KNEE[k], 3'd0});
      push_pair(16'd4096, {3'd0, LUX_KNEE[k], 3'd4});
    end
    wait_drained();

    for (ph = 0; ph < N_PHASES; ph++) begin
      write_reg(lsl_pkg::CFG_INTEGRATION_MODE, PHASE_MODE[ph]);
      write_reg(lsl_pkg::CFG_HIGH_GAIN, {1'b0, PHASE_GAIN[ph]});
      push_pair(16'hFFFF, 16'h0000);
      push_pair(16'hFFFF, 16'h1000);
      queue_random(PHASE_ITEMS);
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && lux_due.size() == 0) begin
      $display("light_sensor_lux_calc_unit regression: pass");
    end else begin
      $display("light_sensor_lux_calc_unit regression: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/lsl_pkg.sv
design/lsl_if.sv
design/light_sensor_lux_calc_unit.sv
dv/tb_light_sensor_lux_calc_unit.sv
